FILE: rtl/core/bgnc_pkg.sv
package bgnc_pkg;

    localparam int GRID_SIZE_W = 7;
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam int HIST_W = 3;
    localparam int TOTAL_W = 4;
    localparam int POS_OUT_W = 6;

    localparam int RES_N = 4;
    localparam int SLOT_W = 2;

    localparam logic [SLOT_W-1:0] SLOT_UP_LEFT = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_UP_EDGE = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LOW_LEFT = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_LOW_EDGE = 2'd3;

    typedef logic [HIST_W-1:0] hist_t;

    typedef struct packed {
        logic [RES_N-1:0] hit;
        logic [RES_N-1:0][TOTAL_W-1:0] total;
    } res_set_t;

    function automatic logic [1:0] pop3(input logic [HIST_W-1:0] x);
        pop3 = 2'(x[0]) + 2'(x[1]) + 2'(x[2]);
    endfunction

endpackage

FILE: rtl/core/bgnc_cell.sv
module bgnc_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 6
) (
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic [POS_W-1:0]     side_last,
    input  bgnc_pkg::hist_t      new_hist,
    input  bgnc_pkg::hist_t      right_hist,
    output bgnc_pkg::hist_t      hist
);

    bgnc_pkg::hist_t hist_reg;
    bgnc_pkg::hist_t hist_next;
    logic            insert;

    assign insert = (side_last == POS_W'(INDEX));

    always_comb
    begin
        hist_next = hist_reg;
        if (shift_en)
        begin
            hist_next = insert ? new_hist : right_hist;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign hist = hist_reg;

endmodule

FILE: rtl/core/bgnc_count.sv
module bgnc_count #(
    parameter int POS_W = 6
) (
    input  logic                 clk,
    input  logic                 accept,
    input  logic                 cell_set,
    input  bgnc_pkg::hist_t      old_hist,
    input  logic [POS_W-1:0]     row,
    input  logic [POS_W-1:0]     col,
    input  logic [POS_W-1:0]     side_last,
    output bgnc_pkg::hist_t      new_hist,
    output bgnc_pkg::res_set_t   res
);

    bgnc_pkg::hist_t w1_reg;
    bgnc_pkg::hist_t w1_next;
    bgnc_pkg::hist_t w2_reg;
    bgnc_pkg::hist_t w2_next;

    bgnc_pkg::hist_t h0;
    bgnc_pkg::hist_t m_up;
    bgnc_pkg::hist_t m_low;
    logic            row_ge1;
    logic            row_ge2;
    logic            col_ge1;
    logic            col_ge2;
    logic            row_end;
    logic            col_end;
    logic [bgnc_pkg::TOTAL_W-1:0] t_up_a;
    logic [bgnc_pkg::TOTAL_W-1:0] t_up_b;
    logic [bgnc_pkg::TOTAL_W-1:0] t_low_a;
    logic [bgnc_pkg::TOTAL_W-1:0] t_low_b;

    assign h0 = {old_hist[1:0], cell_set};
    assign new_hist = h0;

    assign row_ge1 = (row != '0);
    assign row_ge2 = (row > POS_W'(1));
    assign col_ge1 = (col != '0);
    assign col_ge2 = (col > POS_W'(1));
    assign row_end = (row == side_last);
    assign col_end = (col == side_last);

    assign m_up  = {row_ge2, 1'b1, 1'b1};
    assign m_low = {1'b0, row_ge1, 1'b1};

    always_comb
    begin
        t_up_a = bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(h0 & m_up))
               + bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w1_reg & m_up))
               + (col_ge2 ? bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w2_reg & m_up))
                          : bgnc_pkg::TOTAL_W'(0));
        t_up_b = bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(h0 & m_up))
               + (col_ge1 ? bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w1_reg & m_up))
                          : bgnc_pkg::TOTAL_W'(0));
        t_low_a = bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(h0 & m_low))
                + bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w1_reg & m_low))
                + (col_ge2 ? bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w2_reg & m_low))
                           : bgnc_pkg::TOTAL_W'(0));
        t_low_b = bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(h0 & m_low))
                + (col_ge1 ? bgnc_pkg::TOTAL_W'(bgnc_pkg::pop3(w1_reg & m_low))
                           : bgnc_pkg::TOTAL_W'(0));
    end

    always_comb
    begin
        res.hit[bgnc_pkg::SLOT_UP_LEFT]    = row_ge1 && col_ge1;
        res.hit[bgnc_pkg::SLOT_UP_EDGE]    = row_ge1 && col_end;
        res.hit[bgnc_pkg::SLOT_LOW_LEFT]   = row_end && col_ge1;
        res.hit[bgnc_pkg::SLOT_LOW_EDGE]   = row_end && col_end;
        res.total[bgnc_pkg::SLOT_UP_LEFT]  = t_up_a;
        res.total[bgnc_pkg::SLOT_UP_EDGE]  = t_up_b;
        res.total[bgnc_pkg::SLOT_LOW_LEFT] = t_low_a;
        res.total[bgnc_pkg::SLOT_LOW_EDGE] = t_low_b;
    end

    always_comb
    begin
        w1_next = w1_reg;
        w2_next = w2_reg;
        if (accept)
        begin
            w1_next = h0;
            w2_next = w1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg <= w1_next;
        w2_reg <= w2_next;
    end

endmodule

FILE: rtl/core/bgnc_emit.sv
module bgnc_emit #(
    parameter int POS_W = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  bgnc_pkg::res_set_t                  res,
    input  logic [POS_W-1:0]                    row,
    input  logic [POS_W-1:0]                    col,
    output logic                                take_ok,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bgnc_pkg::POS_OUT_W-1:0]      out_row,
    output logic [bgnc_pkg::POS_OUT_W-1:0]      out_col,
    output logic [bgnc_pkg::TOTAL_W-1:0]        neighbor_total,
    output logic                                run_end
);

    logic [bgnc_pkg::RES_N-1:0]                 pend_hit_reg;
    logic [bgnc_pkg::RES_N-1:0]                 pend_hit_next;
    logic [bgnc_pkg::RES_N-1:0][bgnc_pkg::TOTAL_W-1:0] pend_total_reg;
    logic [bgnc_pkg::RES_N-1:0][bgnc_pkg::TOTAL_W-1:0] pend_total_next;
    logic [POS_W-1:0]                           pend_row_reg;
    logic [POS_W-1:0]                           pend_row_next;
    logic [POS_W-1:0]                           pend_col_reg;
    logic [POS_W-1:0]                           pend_col_next;

    logic                                       out_valid_reg;
    logic                                       out_valid_next;
    logic [bgnc_pkg::POS_OUT_W-1:0]             out_row_reg;
    logic [bgnc_pkg::POS_OUT_W-1:0]             out_row_next;
    logic [bgnc_pkg::POS_OUT_W-1:0]             out_col_reg;
    logic [bgnc_pkg::POS_OUT_W-1:0]             out_col_next;
    logic [bgnc_pkg::TOTAL_W-1:0]               out_total_reg;
    logic [bgnc_pkg::TOTAL_W-1:0]               out_total_next;
    logic                                       run_end_reg;
    logic                                       run_end_next;

    logic                                       out_free;
    logic                                       load;
    logic [bgnc_pkg::SLOT_W-1:0]                sel;
    logic [bgnc_pkg::RES_N-1:0]                 remaining;
    logic [POS_W-1:0]                           sel_row;
    logic [POS_W-1:0]                           sel_col;

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (pend_hit_reg != '0) && out_free;

    always_comb
    begin
        priority if (pend_hit_reg[bgnc_pkg::SLOT_UP_LEFT])
        begin
            sel = bgnc_pkg::SLOT_UP_LEFT;
        end
        else if (pend_hit_reg[bgnc_pkg::SLOT_UP_EDGE])
        begin
            sel = bgnc_pkg::SLOT_UP_EDGE;
        end
        else if (pend_hit_reg[bgnc_pkg::SLOT_LOW_LEFT])
        begin
            sel = bgnc_pkg::SLOT_LOW_LEFT;
        end
        else
        begin
            sel = bgnc_pkg::SLOT_LOW_EDGE;
        end
    end

    always_comb
    begin
        remaining      = pend_hit_reg;
        remaining[sel] = 1'b0;
    end

    assign sel_row = (sel == bgnc_pkg::SLOT_UP_LEFT || sel == bgnc_pkg::SLOT_UP_EDGE)
                   ? pend_row_reg - POS_W'(1) : pend_row_reg;
    assign sel_col = (sel == bgnc_pkg::SLOT_UP_LEFT || sel == bgnc_pkg::SLOT_LOW_LEFT)
                   ? pend_col_reg - POS_W'(1) : pend_col_reg;

    assign take_ok = (pend_hit_reg == '0) || (load && (remaining == '0));

    always_comb
    begin
        pend_hit_next   = pend_hit_reg;
        pend_total_next = pend_total_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        if (accept)
        begin
            pend_hit_next   = res.hit;
            pend_total_next = res.total;
            pend_row_next   = row;
            pend_col_next   = col;
        end
        else if (load)
        begin
            pend_hit_next = remaining;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_total_next = out_total_reg;
        run_end_next   = run_end_reg;
        if (out_free)
        begin
            out_valid_next = load;
        end
        if (load)
        begin
            out_row_next   = bgnc_pkg::POS_OUT_W'(sel_row);
            out_col_next   = bgnc_pkg::POS_OUT_W'(sel_col);
            out_total_next = pend_total_reg[sel];
            run_end_next   = (remaining == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_hit_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_hit_reg  <= pend_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_total_reg <= pend_total_next;
        pend_row_reg   <= pend_row_next;
        pend_col_reg   <= pend_col_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_total_reg  <= out_total_next;
        run_end_reg    <= run_end_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_row        = out_row_reg;
    assign out_col        = out_col_reg;
    assign neighbor_total = out_total_reg;
    assign run_end        = run_end_reg;

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pend_hit_reg == $past(res.hit)))
        else $error("accepted result set not captured");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (remaining == '0)) |=> run_end_reg)
        else $error("final result of an item lacks run_end");

endmodule

FILE: rtl/core/binary_grid_neighbor_count_unit.sv
// Path: an item's result set is registered as the pending set, then moves result by result into
// the single output register, one entry per cycle while out_stall is low. Throughput: one item
// per cycle while each item gives at most one result and the output is not stalled; an item with
// more results (up to four at row and grid ends) stalls the input until its pending set drains.
// Reset: position returns to row 0, column 0 and grid_size to 64; the column chain is not
// cleared, since only rows of the current grid are ever counted.
module binary_grid_neighbor_count_unit #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bgnc_pkg::GRID_SIZE_W-1:0]        grid_size,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    cell_set,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [bgnc_pkg::POS_OUT_W-1:0]          out_row,
    output logic [bgnc_pkg::POS_OUT_W-1:0]          out_col,
    output logic [bgnc_pkg::TOTAL_W-1:0]            neighbor_total,
    output logic                                    run_end
);

    localparam int POS_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int RESET_SIDE = (MAX_SIDE < int'(bgnc_pkg::GRID_SIZE_RESET))
                              ? MAX_SIDE : int'(bgnc_pkg::GRID_SIZE_RESET);
    localparam logic [POS_W-1:0] RESET_LAST = POS_W'(RESET_SIDE - 1);

    logic [POS_W-1:0]    side_last_reg;
    logic [POS_W-1:0]    side_last_next;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    row_next;
    logic [POS_W-1:0]    col_reg;
    logic [POS_W-1:0]    col_next;

    logic                cfg_write;
    logic                accept;
    logic                take_ok;
    bgnc_pkg::hist_t     new_hist;
    bgnc_pkg::hist_t     chain_hist [MAX_SIDE];
    bgnc_pkg::res_set_t  res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = !take_ok;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        side_last_next = side_last_reg;
        if (cfg_write)
        begin
            if (grid_size == '0)
            begin
                side_last_next = '0;
            end
            else if (32'(grid_size) >= MAX_SIDE)
            begin
                side_last_next = POS_W'(MAX_SIDE - 1);
            end
            else
            begin
                side_last_next = POS_W'(grid_size - bgnc_pkg::GRID_SIZE_W'(1));
            end
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == side_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == side_last_reg) ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_last_reg <= RESET_LAST;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            side_last_reg <= side_last_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    for (genvar k = 0; k < MAX_SIDE; k++)
    begin : g_cell
        bgnc_pkg::hist_t right_hist;
        if (k == MAX_SIDE - 1)
        begin : g_tail
            assign right_hist = '0;
        end
        else
        begin : g_link
            assign right_hist = chain_hist[k+1];
        end

        bgnc_cell #(
            .INDEX (k),
            .POS_W (POS_W)
        ) u_cell (
            .clk        (clk),
            .shift_en   (accept),
            .side_last  (side_last_reg),
            .new_hist   (new_hist),
            .right_hist (right_hist),
            .hist       (chain_hist[k])
        );
    end

    bgnc_count #(
        .POS_W (POS_W)
    ) u_count (
        .clk       (clk),
        .accept    (accept),
        .cell_set  (cell_set),
        .old_hist  (chain_hist[0]),
        .row       (row_reg),
        .col       (col_reg),
        .side_last (side_last_reg),
        .new_hist  (new_hist),
        .res       (res)
    );

    bgnc_emit #(
        .POS_W (POS_W)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .res            (res),
        .row            (row_reg),
        .col            (col_reg),
        .take_ok        (take_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_row        (out_row),
        .out_col        (out_col),
        .neighbor_total (neighbor_total),
        .run_end        (run_end)
    );

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (row_reg == '0 && col_reg == '0))
        else $error("grid not restarted after grid_size write");

    a_grid_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write && row_reg == side_last_reg && col_reg == side_last_reg)
        |=> (row_reg == '0 && col_reg == '0))
        else $error("position did not wrap at grid end");

endmodule

FILE: tb/sv/binary_grid_neighbor_count_checker.sv
module binary_grid_neighbor_count_checker #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bgnc_pkg::GRID_SIZE_W-1:0]    grid_size,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                cell_set,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [bgnc_pkg::POS_OUT_W-1:0]      out_row,
    input  logic [bgnc_pkg::POS_OUT_W-1:0]      out_col,
    input  logic [bgnc_pkg::TOTAL_W-1:0]        neighbor_total,
    input  logic                                run_end,
    output int                                  failures,
    output int                                  pending
);

    typedef struct packed {
        logic [bgnc_pkg::POS_OUT_W-1:0] row;
        logic [bgnc_pkg::POS_OUT_W-1:0] col;
        logic [bgnc_pkg::TOTAL_W-1:0]   total;
        logic                           ends_run;
    } cell_count_t;

    logic [bgnc_pkg::HIST_W-1:0]      col_bits [MAX_SIDE];
    logic [bgnc_pkg::GRID_SIZE_W-1:0] side_cfg;
    int                               cur_row;
    int                               cur_col;
    cell_count_t                      due_counts [$];
    cell_count_t                      want;

    function automatic int side_in_use();
        if (side_cfg < 1)
        begin
            return 1;
        end
        if (side_cfg > MAX_SIDE)
        begin
            return MAX_SIDE;
        end
        return int'(side_cfg);
    endfunction

    // Count set cells around (r, c) while row cur is the newest row held per column.
    function automatic int window_total(int r, int c, int cur, int n);
        int total;
        int q;
        int cc;
        int age;
        total = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            q = r + dr;
            if (q >= 0 && q < n && q <= cur && cur - q <= 2)
            begin
                age = cur - q;
                for (int dc = -1; dc <= 1; dc++)
                begin
                    cc = c + dc;
                    if (cc >= 0 && cc < n)
                    begin
                        total += col_bits[cc][age];
                    end
                end
            end
        end
        return total;
    endfunction

    function automatic void take_cell(logic b);
        int n;
        int last_idx;
        int i;
        int j;
        int k;
        int row_of [4];
        int col_of [4];
        n = side_in_use();
        last_idx = n - 1;
        i = cur_row;
        j = cur_col;
        k = 0;
        if (i > last_idx || j > last_idx)
        begin
            i = 0;
            j = 0;
        end
        col_bits[j] = {col_bits[j][bgnc_pkg::HIST_W-2:0], b};
        if (i >= 1 && j >= 1)
        begin
            row_of[k] = i - 1;
            col_of[k] = j - 1;
            k++;
        end
        if (i >= 1 && j == last_idx)
        begin
            row_of[k] = i - 1;
            col_of[k] = last_idx;
            k++;
        end
        if (i == last_idx && j >= 1)
        begin
            row_of[k] = i;
            col_of[k] = j - 1;
            k++;
        end
        if (i == last_idx && j == last_idx)
        begin
            row_of[k] = i;
            col_of[k] = j;
            k++;
        end
        for (int m = 0; m < k; m++)
        begin
            due_counts.push_back('{row: bgnc_pkg::POS_OUT_W'(row_of[m]),
                                   col: bgnc_pkg::POS_OUT_W'(col_of[m]),
                                   total: bgnc_pkg::TOTAL_W'(
                                       window_total(row_of[m], col_of[m], i, n)),
                                   ends_run: (m == k - 1)});
        end
        j++;
        if (j >= n)
        begin
            j = 0;
            i++;
            if (i >= n)
            begin
                i = 0;
            end
        end
        cur_row = i;
        cur_col = j;
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg = bgnc_pkg::GRID_SIZE_RESET;
            cur_row = 0;
            cur_col = 0;
            for (int m = 0; m < MAX_SIDE; m++)
            begin
                col_bits[m] = '0;
            end
            due_counts.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_counts.size() == 0)
                begin
                    $error("unexpected transfer: row %0d, col %0d, total %0d",
                           out_row, out_col, neighbor_total);
                    failures++;
                end
                else
                begin
                    want = due_counts.pop_front();
                    check_field("out_row", want.row, out_row);
                    check_field("out_col", want.col, out_col);
                    check_field("neighbor_total", want.total, neighbor_total);
                    check_field("run_end", want.ends_run, run_end);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                side_cfg = grid_size;
                cur_row = 0;
                cur_col = 0;
            end
            if (in_valid && !in_stall)
            begin
                take_cell(cell_set);
            end
            pending = due_counts.size();
        end
    end

endmodule

FILE: tb/sv/binary_grid_neighbor_count_unit_test.sv
module binary_grid_neighbor_count_unit_test;

    localparam int MAX_SIDE = 64;
    localparam int RANDOM_PER_PHASE = 120;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bgnc_pkg::GRID_SIZE_W-1:0] grid_size = bgnc_pkg::GRID_SIZE_RESET;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             cell_set = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [bgnc_pkg::POS_OUT_W-1:0]   out_row;
    logic [bgnc_pkg::POS_OUT_W-1:0]   out_col;
    logic [bgnc_pkg::TOTAL_W-1:0]     neighbor_total;
    logic                             run_end;
    int                               failures;
    int                               pending;
    int                               send_pct = 21;
    int                               recv_pct = 73;

    binary_grid_neighbor_count_unit #(
        .MAX_SIDE(MAX_SIDE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .grid_size(grid_size),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cell_set(cell_set),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_row(out_row),
        .out_col(out_col),
        .neighbor_total(neighbor_total),
        .run_end(run_end)
    );

    binary_grid_neighbor_count_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) count_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .grid_size(grid_size),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cell_set(cell_set),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_row(out_row),
        .out_col(out_col),
        .neighbor_total(neighbor_total),
        .run_end(run_end),
        .failures(failures),
        .pending(pending)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_cell(input logic b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cell_set <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Hold the sender until every pending count has made its transfer.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_side(input logic [bgnc_pkg::GRID_SIZE_W-1:0] side);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        grid_size <= side;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [bgnc_pkg::GRID_SIZE_W-1:0] pick_side();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            return bgnc_pkg::GRID_SIZE_W'($urandom_range(2, 6));
        end
        if (sel < 72)
        begin
            return bgnc_pkg::GRID_SIZE_W'($urandom_range(7, 12));
        end
        if (sel < 80)
        begin
            return bgnc_pkg::GRID_SIZE_W'($urandom_range(0, 1));
        end
        if (sel < 88)
        begin
            return bgnc_pkg::GRID_SIZE_W'($urandom_range(13, 63));
        end
        return bgnc_pkg::GRID_SIZE_W'($urandom_range(64, 127));
    endfunction

    initial
    begin
        logic [bgnc_pkg::GRID_SIZE_W-1:0] side;
        int eff;
        int span;
        int density;
        int sent;
        int pause_at;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default size, one-cell grids, clamped sizes, wrap, full window.
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
        write_side(bgnc_pkg::GRID_SIZE_W'(1));
        send_cell(1'b0);
        send_cell(1'b1);
        send_cell(1'b1);
        write_side(bgnc_pkg::GRID_SIZE_W'(0));
        send_cell(1'b1);
        send_cell(1'b0);
        write_side(bgnc_pkg::GRID_SIZE_W'(127));
        send_cell(1'b1);
        send_cell(1'b1);
        write_side(bgnc_pkg::GRID_SIZE_W'(2));
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b0);
        write_side(bgnc_pkg::GRID_SIZE_W'(3));
        repeat (9) send_cell(1'b1);
        send_cell(1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_pct = (phase == 0) ? 21 : (phase == 1) ? 73 : 0;
            recv_pct = (phase == 0) ? 73 : (phase == 1) ? 21 : 0;
            sent = 0;
            pause_at = $urandom_range(20, 100);
            while (sent < RANDOM_PER_PHASE)
            begin
                side = pick_side();
                write_side(side);
                eff = (side < 1) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : int'(side);
                span = (eff <= 12) ? $urandom_range(1, 2 * eff * eff + 2)
                                   : $urandom_range(10, 80);
                if (span > RANDOM_PER_PHASE - sent)
                begin
                    span = RANDOM_PER_PHASE - sent;
                end
                density = $urandom_range(0, 100);
                repeat (span)
                begin
                    send_cell($urandom_range(0, 99) < density);
                    sent++;
                    if (sent == pause_at)
                    begin
                        settle();
                    end
                end
            end
        end

        settle();
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bgnc_pkg.sv
rtl/core/bgnc_cell.sv
rtl/core/bgnc_count.sv
rtl/core/bgnc_emit.sv
rtl/core/binary_grid_neighbor_count_unit.sv
tb/sv/binary_grid_neighbor_count_checker.sv
tb/sv/binary_grid_neighbor_count_unit_test.sv
